// File: design/gpr_pkg.sv
// Shared types, constants and the round-and-clamp helper for the pyramid reduce block.
// No dependencies; gpr_front, gpr_back and the top level import this package.
`default_nettype none

package gpr_pkg;

  // Geometry and arithmetic constants
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int HEIGHT_LIMIT   = 2048;
  localparam int MIN_SIZE       = 8;
  localparam int WIN_DEPTH      = 7;
  localparam int COEF_FRAC_BITS = 14;
  localparam int PIX_MAX        = 255;
  localparam int COEF_W         = 16;
  localparam int PSUM_W         = 9;
  localparam int PROD_W         = COEF_W + PSUM_W + 1;
  localparam int SUM_W          = PROD_W + 2;
  localparam int IL_W           = 12;
  localparam int ROW_W          = 11;
  localparam int CFG_W          = 12;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int MID_DEPTH      = 4;
  localparam int OUT_DEPTH      = 8;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_TAP_RADIUS,
    REG_COEF_CENTER,
    REG_COEF_ONE,
    REG_COEF_TWO,
    REG_COEF_THREE
  } reg_idx_t;

  // Reset values of the registers
  localparam logic [CFG_W-1:0]  RST_WIDTH  = 12'd512;
  localparam logic [CFG_W-1:0]  RST_HEIGHT = 12'd512;
  localparam logic [1:0]        RST_RADIUS = 2'd2;
  localparam logic [COEF_W-1:0] RST_COEF0  = 16'd6554;
  localparam logic [COEF_W-1:0] RST_COEF1  = 16'd4096;
  localparam logic [COEF_W-1:0] RST_COEF2  = 16'd819;
  localparam logic [COEF_W-1:0] RST_COEF3  = 16'd0;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pix_t;

  typedef struct packed {
    logic [7:0] out_pixel;
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic       run_last;
  } res_t;

  // One horizontal column to form: tap pair sums, radius already applied
  typedef struct packed {
    logic                         valid;
    logic [IL_W-1:0]              il;
    logic [3:0][PSUM_W-1:0]       hs;
  } hitem_t;

  // One output row to form: line store slots of taps -3..+3 (index 3 is center)
  typedef struct packed {
    logic                         valid;
    logic [9:0]                   jrow;
    logic [WIN_DEPTH-1:0][2:0]    slot;
  } jitem_t;

  // Work handed from the front to the back
  typedef struct packed {
    logic [3:0][COEF_W-1:0] coef;
    logic [1:0]             r;
    logic [2:0]             wslot;
    hitem_t [1:0]           h;
    jitem_t [1:0]           j;
  } entry_t;

  // Round half away from zero at the fraction point, clamp to 0..255
  function automatic logic [7:0] round_clamp(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0] q;
    q = ($unsigned(s) + SUM_W'(1 << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
    if (s < 0) begin
      return 8'd0;
    end
    if (q > SUM_W'(PIX_MAX)) begin
      return 8'(PIX_MAX);
    end
    return q[7:0];
  endfunction

endpackage

`default_nettype wire

// File: design/gpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/gpr_fifo.sv
// Small first-in first-out queue of any packed item type.
// No package dependency; used for the work queue and the result queue.
`default_nettype none

module gpr_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t din,
  output logic  full,
  input  logic  pop,
  output item_t dout,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  item_t mem [DEPTH];
  logic [AW-1:0]   wp;
  logic [AW-1:0]   rp;
  logic [CNTW-1:0] cnt;

  assign full  = (cnt == CNTW'(DEPTH));
  assign empty = (cnt == '0);
  assign dout  = mem[rp];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Store the item
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

endmodule

`default_nettype wire

// File: design/gpr_front.sv
// Front part: configuration registers, frame position, row window and classification
// of each pixel into horizontal columns and output rows to form. Uses gpr_pkg.
`default_nettype none

module gpr_front import gpr_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pix_t                  pix,
  output logic                  full,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_full,
  output logic                  q_push,
  output entry_t                q_item
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PW = ((CW > CFG_W) ? CW : CFG_W) + 2;

  typedef struct packed {
    logic [1:0] k0;
    logic       v0;
    logic [1:0] k1;
    logic       v1;
  } pick_t;

  function automatic logic [2:0] mod7(input logic [4:0] v);
    if (v >= 5'd14) begin
      return 3'(v - 5'd14);
    end
    if (v >= 5'd7) begin
      return 3'(v - 5'd7);
    end
    return v[2:0];
  endfunction

  // Storage slot of position pos+d, mirrored at both borders
  function automatic logic [2:0] slot_of(input logic signed [PW-1:0] pos,
                                         input logic signed [PW-1:0] last,
                                         input logic [2:0] m7,
                                         input logic signed [3:0] d);
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] nx;
    x  = pos + PW'(d);
    nx = -x;
    if (x < 0) begin
      return nx[2:0];
    end
    if (x > last) begin
      return mod7(5'({2'b00, m7}) + 5'd7 - 5'(d));
    end
    return mod7(5'({2'b00, m7}) + 5'd7 + 5'(d));
  endfunction

  // Choose the offsets k (position minus k is even) to form at this step
  function automatic pick_t pick_k(input logic lsb, input logic at_end, input logic ge_r,
                                   input logic [1:0] r);
    pick_t p;
    logic  par;
    par  = (lsb == r[0]);
    p.k0 = r;
    p.v0 = ge_r && par;
    p.k1 = 2'd0;
    p.v1 = 1'b0;
    if (at_end) begin
      p.k0 = par ? r : r - 2'd1;
      p.v0 = par || (r != 2'd0);
      p.k1 = p.k0 - 2'd2;
      p.v1 = p.v0 && (p.k0 >= 2'd2);
    end
    return p;
  endfunction

  // Configuration registers
  logic [CFG_W-1:0]       cfg_w;
  logic [CFG_W-1:0]       cfg_h;
  logic [1:0]             cfg_r;
  logic [3:0][COEF_W-1:0] cfg_c;

  // Values latched at frame start
  logic [CFG_W-1:0]       lat_w;
  logic [CFG_W-1:0]       lat_h;
  logic [1:0]             lat_r;
  logic [3:0][COEF_W-1:0] lat_c;

  // Position and window
  logic [CW-1:0]          col;
  logic [ROW_W-1:0]       row;
  logic [2:0]             cm7;
  logic [2:0]             rm7;
  logic [WIN_DEPTH-1:0][7:0] win;

  logic                   accept;
  logic                   start;
  logic [CW-1:0]          e_col;
  logic [ROW_W-1:0]       e_row;
  logic [2:0]             e_cm7;
  logic [2:0]             e_rm7;
  logic [CFG_W-1:0]       e_w;
  logic [CFG_W-1:0]       e_h;
  logic [1:0]             e_r;
  logic [3:0][COEF_W-1:0] e_c;
  logic [CFG_W-1:0]       clamp_w;
  logic [CFG_W-1:0]       clamp_h;
  logic signed [PW-1:0]   colp;
  logic signed [PW-1:0]   rowp;
  logic signed [PW-1:0]   wl;
  logic signed [PW-1:0]   hl;
  logic                   row_end;
  logic                   last_row;
  logic [7:0][7:0]        win_n;
  pick_t                  hp;
  pick_t                  jp;

  assign cfg_ready = 1'b1;
  assign accept    = push && !q_full;
  assign full      = q_full;
  assign start     = pix.frame_start || ((row == '0) && (col == '0));

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= RST_WIDTH;
      cfg_h <= RST_HEIGHT;
      cfg_r <= RST_RADIUS;
      cfg_c <= {RST_COEF3, RST_COEF2, RST_COEF1, RST_COEF0};
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_IMAGE_WIDTH:  cfg_w    <= cfg_data[CFG_W-1:0];
        REG_IMAGE_HEIGHT: cfg_h    <= cfg_data[CFG_W-1:0];
        REG_TAP_RADIUS:   cfg_r    <= cfg_data[1:0];
        REG_COEF_CENTER:  cfg_c[0] <= cfg_data;
        REG_COEF_ONE:     cfg_c[1] <= cfg_data;
        REG_COEF_TWO:     cfg_c[2] <= cfg_data;
        REG_COEF_THREE:   cfg_c[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp geometry and pick latched or fresh settings
  always_comb begin
    clamp_w = cfg_w;
    if (cfg_w < CFG_W'(MIN_SIZE)) begin
      clamp_w = CFG_W'(MIN_SIZE);
    end else if (int'(cfg_w) > MAX_WIDTH) begin
      clamp_w = CFG_W'(MAX_WIDTH);
    end
    clamp_h = cfg_h;
    if (cfg_h < CFG_W'(MIN_SIZE)) begin
      clamp_h = CFG_W'(MIN_SIZE);
    end else if (cfg_h > CFG_W'(HEIGHT_LIMIT)) begin
      clamp_h = CFG_W'(HEIGHT_LIMIT);
    end
    e_w   = start ? clamp_w : lat_w;
    e_h   = start ? clamp_h : lat_h;
    e_r   = start ? cfg_r : lat_r;
    e_c   = start ? cfg_c : lat_c;
    e_col = pix.frame_start ? '0 : col;
    e_row = pix.frame_start ? '0 : row;
    e_cm7 = pix.frame_start ? 3'd0 : cm7;
    e_rm7 = pix.frame_start ? 3'd0 : rm7;
    colp  = PW'(e_col);
    rowp  = PW'(e_row);
    wl    = PW'(e_w) - PW'(1);
    hl    = PW'(e_h) - PW'(1);
    row_end  = (colp == wl);
    last_row = (rowp == hl);
    for (int e = 0; e < 8; e++) begin
      win_n[e] = 8'd0;
    end
    for (int e = 0; e < WIN_DEPTH; e++) begin
      win_n[e] = (3'(e) == e_cm7) ? pix.pixel : win[e];
    end
  end

  // Classify the pixel: columns and rows to form, with their taps
  always_comb begin
    logic [1:0]           k;
    logic signed [3:0]    dp;
    logic signed [3:0]    dm;
    logic [7:0]           a;
    logic [7:0]           b;
    logic signed [PW-1:0] pv;
    hp = pick_k(e_col[0], row_end, colp >= PW'(e_r), e_r);
    jp = pick_k(e_row[0], last_row, rowp >= PW'(e_r), e_r);
    q_item.coef  = e_c;
    q_item.r     = e_r;
    q_item.wslot = e_rm7;
    for (int hh = 0; hh < 2; hh++) begin
      k  = (hh == 1) ? hp.k1 : hp.k0;
      pv = colp - PW'(k);
      q_item.h[hh].valid = (hh == 1) ? hp.v1 : hp.v0;
      q_item.h[hh].il    = pv[IL_W:1];
      for (int n = 0; n < 4; n++) begin
        dp = 4'(n) - 4'({2'b00, k});
        dm = 4'(0) - 4'(n) - 4'({2'b00, k});
        a  = win_n[slot_of(colp, wl, e_cm7, dp)];
        b  = win_n[slot_of(colp, wl, e_cm7, dm)];
        if (n == 0) begin
          q_item.h[hh].hs[n] = {1'b0, a};
        end else if (2'(n) <= e_r) begin
          q_item.h[hh].hs[n] = {1'b0, a} + {1'b0, b};
        end else begin
          q_item.h[hh].hs[n] = '0;
        end
      end
    end
    for (int jj = 0; jj < 2; jj++) begin
      k  = (jj == 1) ? jp.k1 : jp.k0;
      pv = rowp - PW'(k);
      q_item.j[jj].valid = (jj == 1) ? jp.v1 : jp.v0;
      q_item.j[jj].jrow  = pv[10:1];
      for (int n = 0; n < 4; n++) begin
        dp = 4'(n) - 4'({2'b00, k});
        dm = 4'(0) - 4'(n) - 4'({2'b00, k});
        q_item.j[jj].slot[3 + n] = slot_of(rowp, hl, e_rm7, dp);
        q_item.j[jj].slot[3 - n] = slot_of(rowp, hl, e_rm7, dm);
      end
    end
    q_push = accept && hp.v0;
  end

  // Latch settings at frame start
  always_ff @(posedge clk) begin
    if (accept && start) begin
      lat_w <= clamp_w;
      lat_h <= clamp_h;
      lat_r <= cfg_r;
      lat_c <= cfg_c;
    end
  end

  // Advance position and store the pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      cm7 <= 3'd0;
      rm7 <= 3'd0;
      win <= '0;
    end else if (accept) begin
      win <= win_n[WIN_DEPTH-1:0];
      if (row_end) begin
        col <= '0;
        cm7 <= 3'd0;
        if (last_row) begin
          row <= '0;
          rm7 <= 3'd0;
        end else begin
          row <= e_row + 1'b1;
          rm7 <= (e_rm7 == 3'(WIN_DEPTH - 1)) ? 3'd0 : e_rm7 + 3'd1;
        end
      end else begin
        col <= e_col + 1'b1;
        row <= e_row;
        rm7 <= e_rm7;
        cm7 <= (e_cm7 == 3'(WIN_DEPTH - 1)) ? 3'd0 : e_cm7 + 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/gpr_back.sv
// Back part: issues one column/row task per cycle from the work queue while the
// result queue has room, runs the horizontal and vertical filters around the line
// store banks, queues results. Uses gpr_pkg, gpr_ram and gpr_fifo.
`default_nettype none

module gpr_back import gpr_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  entry_t ent,
  input  logic   ent_valid,
  output logic   ent_pop,
  output res_t   res,
  output logic   empty,
  input  logic   pop
);

  localparam int LS_COLS = (MAX_WIDTH + 1) / 2;
  localparam int ILW     = $clog2(LS_COLS);
  localparam int FW      = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [3:0][COEF_W-1:0]    coef;
    logic [1:0]                r;
    logic [2:0]                wslot;
    logic [IL_W-1:0]           il;
    logic [WIN_DEPTH-1:0][2:0] slot;
    logic [9:0]                jrow;
    logic                      has_out;
    logic                      run_last;
  } meta_t;

  // Task sequencer
  logic       hsel;
  logic       jsel;
  logic [FW-1:0] inflight;
  hitem_t     hcur;
  jitem_t     jcur;
  logic       hlast;
  logic       jlast;
  logic       tlast;
  logic       issue;
  logic       out_pop;
  logic       out_push;
  res_t       out_item;
  logic       out_full;

  // Pipeline stages
  logic v1, v2, v3, v4, v5, v6;
  meta_t m1, m2, m3, m4, m5, m6;
  logic [3:0][PSUM_W-1:0]   hs1;
  logic signed [PROD_W-1:0] hp2 [4];
  logic [7:0]               hval3;
  logic [7:0]               hval4;
  logic [3:0][PSUM_W-1:0]   vs5;
  logic signed [PROD_W-1:0] vp6 [4];
  logic signed [SUM_W-1:0]  hsum;
  logic signed [SUM_W-1:0]  vsum;
  logic [7:0]               rd [WIN_DEPTH];
  logic [7:0][7:0]          tap;
  logic [3:0][PSUM_W-1:0]   vs;

  // Select the current task
  always_comb begin
    hcur    = hsel ? ent.h[1] : ent.h[0];
    jcur    = jsel ? ent.j[1] : ent.j[0];
    hlast   = hsel || !ent.h[1].valid;
    jlast   = jsel || !ent.j[1].valid;
    tlast   = hlast && jlast;
    issue   = ent_valid && (!jcur.valid || (inflight < FW'(OUT_DEPTH)));
    ent_pop = issue && tlast;
    out_pop = pop && !empty;
  end

  // Step through tasks and count results owed to the result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      hsel     <= 1'b0;
      jsel     <= 1'b0;
      inflight <= '0;
    end else begin
      if (issue) begin
        if (tlast) begin
          hsel <= 1'b0;
          jsel <= 1'b0;
        end else if (!jlast) begin
          jsel <= 1'b1;
        end else begin
          hsel <= 1'b1;
          jsel <= 1'b0;
        end
      end
      inflight <= inflight + FW'(issue && jcur.valid) - FW'(out_pop);
    end
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // Horizontal sum, vertical taps and vertical sum
  always_comb begin
    hsum = SUM_W'(hp2[0]) + SUM_W'(hp2[1]) + SUM_W'(hp2[2]) + SUM_W'(hp2[3]);
    vsum = SUM_W'(vp6[0]) + SUM_W'(vp6[1]) + SUM_W'(vp6[2]) + SUM_W'(vp6[3]);
    tap[7] = 8'd0;
    for (int b = 0; b < WIN_DEPTH; b++) begin
      tap[b] = (3'(b) == m4.wslot) ? hval4 : rd[b];
    end
    for (int n = 0; n < 4; n++) begin
      if (n == 0) begin
        vs[n] = {1'b0, tap[m4.slot[3]]};
      end else if (2'(n) <= m4.r) begin
        vs[n] = {1'b0, tap[m4.slot[3 + n]]} + {1'b0, tap[m4.slot[3 - n]]};
      end else begin
        vs[n] = '0;
      end
    end
  end

  // Hold stage payloads
  always_ff @(posedge clk) begin
    m1.coef     <= ent.coef;
    m1.r        <= ent.r;
    m1.wslot    <= ent.wslot;
    m1.il       <= hcur.il;
    m1.slot     <= jcur.slot;
    m1.jrow     <= jcur.jrow;
    m1.has_out  <= jcur.valid;
    m1.run_last <= jcur.valid && tlast;
    hs1         <= hcur.hs;
    m2 <= m1;
    m3 <= m2;
    m4 <= m3;
    m5 <= m4;
    m6 <= m5;
    for (int n = 0; n < 4; n++) begin
      hp2[n] <= $signed(m1.coef[n]) * $signed({1'b0, hs1[n]});
      vp6[n] <= $signed(m5.coef[n]) * $signed({1'b0, vs5[n]});
    end
    hval3 <= round_clamp(hsum);
    hval4 <= hval3;
    vs5   <= vs;
  end

  // Line store: one bank per stored row
  for (genvar b = 0; b < WIN_DEPTH; b++) begin : g_bank
    gpr_ram #(
      .WIDTH (8),
      .DEPTH (LS_COLS)
    ) u_ram (
      .clk   (clk),
      .we    (v3 && (m3.wslot == 3'(b))),
      .waddr (m3.il[ILW-1:0]),
      .wdata (hval3),
      .raddr (m3.il[ILW-1:0]),
      .rdata (rd[b])
    );
  end

  // Queue finished results
  always_comb begin
    out_push          = v6 && m6.has_out;
    out_item.out_pixel = round_clamp(vsum);
    out_item.out_row   = m6.jrow;
    out_item.out_col   = 10'(m6.il);
    out_item.run_last  = m6.run_last;
  end

  gpr_fifo #(
    .item_t (res_t),
    .DEPTH  (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_item),
    .full  (out_full),
    .pop   (out_pop),
    .dout  (res),
    .empty (empty)
  );

  logic unused_full;
  assign unused_full = out_full;

endmodule

`default_nettype wire

// File: design/gaussian_pyramid_reduce.sv
// Top level of the one-level Gaussian pyramid reduce block.
// Uses gpr_pkg, gpr_front, gpr_fifo and gpr_back.
//
// Usage: pixels of the fine image enter in raster order on a queue-style port:
// an item is taken when push is high and full is low; frame_start puts the pixel
// at row 0, column 0. Reduced pixels leave on a queue-style port: the oldest
// result sits on res while empty is low and is taken when pop is high.
// Configuration goes through cfg_valid/cfg_ready (always ready), cfg_index and
// cfg_data; settings are sampled at the first pixel of each frame.
// Throughput: one pixel per cycle while full is low. The back end forms one output
// column/row task per cycle while the result queue has room; a row's last pixel needs
// up to two tasks and a frame's up to four, absorbed by a four-entry work queue.
// With idle queues, the first result of a pixel reaches res through the work queue,
// six filter stages around the line store and a result queue write.
// Reset clears position, window, queues and registers to their default values;
// the line store needs no clearing. When the receiver stalls, the result queue
// fills, the back end stops issuing tasks, then the work queue fills and full rises.
`default_nettype none

module gaussian_pyramid_reduce import gpr_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  pix_t                  pix,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  empty,
  input  logic                  pop,
  output res_t                  res
);

  logic   q_full;
  logic   q_push;
  entry_t q_in;
  entry_t q_out;
  logic   q_empty;
  logic   q_pop;

  gpr_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pix       (pix),
    .full      (full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  gpr_fifo #(
    .item_t (entry_t),
    .DEPTH  (MID_DEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  gpr_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .ent       (q_out),
    .ent_valid (!q_empty),
    .ent_pop   (q_pop),
    .res       (res),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

`default_nettype wire
